// File: rtl/ssdg_pkg.sv
// Shared constants for the step/direction pulse generator.
`timescale 1ns / 1ps
package ssdg_pkg;

    // request kinds carried in the slave-side tuser
    localparam logic [2:0] REQ_TICK     = 3'd0;
    localparam logic [2:0] REQ_RUN_VEL  = 3'd1;
    localparam logic [2:0] REQ_MOVE_ABS = 3'd2;
    localparam logic [2:0] REQ_MOVE_REL = 3'd3;
    localparam logic [2:0] REQ_ENABLE   = 3'd4;
    localparam logic [2:0] REQ_DISABLE  = 3'd5;

    // configuration register indexes
    localparam logic [1:0] CFG_STEPS_PER_REV  = 2'd0;
    localparam logic [1:0] CFG_MIN_PERIOD_US  = 2'd1;
    localparam logic [1:0] CFG_PULSE_WIDTH_US = 2'd2;

    // register widths
    localparam int SPR_W = 16;
    localparam int MINP_W = 16;
    localparam int PW_W = 10;
    localparam int VEL_W = 32;

    // divider geometry: den = steps_per_rev * |velocity| fits 48 bits,
    // as does the rounding numerator 2*N + den
    localparam int DEN_W = SPR_W + VEL_W;
    localparam int CNT_W = $clog2(DEN_W);

    // twice 1e6 microseconds in Q16.16 (2 * 65536e6)
    localparam logic [DEN_W-1:0] NUM_US_Q16_X2 = 48'd131072000000;

    // reset values of the configuration registers
    localparam logic [SPR_W-1:0]  SPR_RESET  = 16'd200;
    localparam logic [MINP_W-1:0] MINP_RESET = 16'd100;
    localparam logic [PW_W-1:0]   PW_RESET   = 10'd5;

endpackage

// File: rtl/stepper_step_dir_generator_top.sv
// Step/direction pulse generator: command sequencer and shared period divider.
// Tick, enable, disable and stop requests pass EXEC and EMIT into the output register;
// a run or move that starts motion also passes MUL, DINIT, the 48-step restoring divider
// in DIV that turns steps_per_rev * |velocity| into a period, and FIN.
// Throughput: one request at a time; the next is taken once the result is in the output
// register. Reset (i_rst_n low, synchronous) restores the register defaults and stops.
`timescale 1ns / 1ps
module stepper_step_dir_generator_top
    import ssdg_pkg::*;
#(
    parameter int PERIOD_BITS = 24,
    parameter int POS_BITS    = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration write channel
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_addr,
    input  logic [15:0]         i_cfg_data,
    // request stream
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  logic [63:0]         i_s_axis_tdata,   // velocity[31:0], target_steps[63:32]
    input  logic [2:0]          i_s_axis_tuser,   // req_type[2:0]
    // result stream
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    // step_out, dir_out, enable_n_out, position, moving, period_us, zero fill
    output logic [((POS_BITS + PERIOD_BITS + 4 + 7) / 8) * 8 - 1:0] o_m_axis_tdata
);

    localparam int OUT_W = ((POS_BITS + PERIOD_BITS + 4 + 7) / 8) * 8;
    localparam logic [PERIOD_BITS-1:0] PERIOD_MAX = {PERIOD_BITS{1'b1}};
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DEN_W - 1);

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_DINIT = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    logic [2:0]             r_state;
    logic [2:0]             r_req;
    logic [VEL_W-1:0]       r_vel;
    logic [31:0]            r_tgt;

    logic [SPR_W-1:0]       r_spr;
    logic [MINP_W-1:0]      r_minp;
    logic [PW_W-1:0]        r_pw;

    logic [POS_BITS-1:0]    r_pos;
    logic [POS_BITS-1:0]    r_target;
    logic                   r_free;
    logic                   r_run;
    logic                   r_dir;
    logic                   r_en_n;
    logic [PERIOD_BITS-1:0] r_period;
    logic [PERIOD_BITS-1:0] r_phase;
    logic [PW_W-1:0]        r_pulse;
    logic                   r_step;

    logic [VEL_W-1:0]       r_mag;
    logic [DEN_W-1:0]       r_den;
    logic [DEN_W-1:0]       r_rem;
    logic [DEN_W-1:0]       r_quo;
    logic [DEN_W:0]         r_div;
    logic [CNT_W-1:0]       r_cnt;

    logic                   r_ovalid;
    logic [OUT_W-1:0]       r_odata;

    // tick next values
    logic                   n_step;
    logic [PW_W-1:0]        n_pulse;
    logic [PERIOD_BITS-1:0] n_phase;
    logic [POS_BITS-1:0]    n_pos;
    logic                   n_dir;
    logic                   n_run;
    logic [PERIOD_BITS-1:0] n_period;
    logic [POS_BITS-1:0]    n_target;
    logic [PERIOD_BITS:0]   phase_inc;
    logic                   ev_dir;
    logic [PW_W-1:0]        pw_eff;

    // command decode
    logic [POS_BITS-1:0]    move_t;
    logic [VEL_W-1:0]       vel_abs;

    // divider step
    logic [DEN_W:0]         trial;
    logic [DEN_W:0]         diff;
    logic                   ge;

    // period finish
    logic [DEN_W-1:0]       lim;
    logic [DEN_W-1:0]       p_lim;
    logic [PERIOD_BITS-1:0] p_fin;

    logic                   s_accept;
    logic                   out_free;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_accept        = i_s_axis_tvalid && (r_state == S_IDLE);
    assign out_free        = !r_ovalid || i_m_axis_tready;
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;

    assign pw_eff  = (r_pw == '0) ? PW_W'(1) : r_pw;
    assign vel_abs = r_vel[VEL_W-1] ? (~r_vel + VEL_W'(1)) : r_vel;
    assign move_t  = (r_req == REQ_MOVE_REL) ? (r_pos + r_tgt[POS_BITS-1:0])
                                             : r_tgt[POS_BITS-1:0];

    // one microsecond tick: pulse countdown first, then the period event
    always_comb begin
        n_step    = r_step;
        n_pulse   = r_pulse;
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_dir     = r_dir;
        n_run     = r_run;
        n_period  = r_period;
        n_target  = r_target;
        phase_inc = {1'b0, r_phase} + (PERIOD_BITS + 1)'(1);
        ev_dir    = r_free ? r_dir : ($signed(r_target) > $signed(r_pos));
        if (r_step && r_pulse != '0) begin
            n_pulse = r_pulse - PW_W'(1);
            if (r_pulse == PW_W'(1)) begin
                n_step = 1'b0;
            end
        end
        if (r_period != '0) begin
            if (phase_inc >= {1'b0, r_period}) begin
                n_phase = '0;
                if (r_run) begin
                    if (!r_free && r_pos == r_target) begin
                        n_run    = 1'b0;
                        n_period = '0;
                        n_target = r_pos;
                    end else begin
                        n_dir   = ev_dir;
                        n_step  = 1'b1;
                        n_pulse = pw_eff;
                        n_pos   = ev_dir ? (r_pos + POS_BITS'(1)) : (r_pos - POS_BITS'(1));
                    end
                end
            end else begin
                n_phase = phase_inc[PERIOD_BITS-1:0];
            end
        end
    end

    // restoring divide step: quotient bits shift in below the dividend
    assign trial = {r_rem, r_quo[DEN_W-1]};
    assign diff  = trial - r_div;
    assign ge    = (trial >= r_div);

    // clamp the quotient to the lower limit and the largest period
    always_comb begin
        lim   = (r_minp == '0) ? DEN_W'(1) : DEN_W'(r_minp);
        p_lim = (r_quo < lim) ? lim : r_quo;
        p_fin = (p_lim > DEN_W'(PERIOD_MAX)) ? PERIOD_MAX : p_lim[PERIOD_BITS-1:0];
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spr  <= SPR_RESET;
            r_minp <= MINP_RESET;
            r_pw   <= PW_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                CFG_STEPS_PER_REV:  r_spr  <= i_cfg_data;
                CFG_MIN_PERIOD_US:  r_minp <= i_cfg_data;
                CFG_PULSE_WIDTH_US: r_pw   <= i_cfg_data[PW_W-1:0];
                default: ;
            endcase
        end
    end

    // request capture and working registers (payload, no reset)
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_req <= i_s_axis_tuser;
            r_vel <= i_s_axis_tdata[31:0];
            r_tgt <= i_s_axis_tdata[63:32];
        end
        if (r_state == S_EXEC) begin
            r_mag <= vel_abs;
        end
        if (r_state == S_MUL) begin
            r_den <= DEN_W'(r_spr) * DEN_W'(r_mag);
        end
        if (r_state == S_DINIT) begin
            r_rem <= '0;
            r_quo <= NUM_US_Q16_X2 + r_den;
            r_div <= {r_den, 1'b0};
            r_cnt <= '0;
        end
        if (r_state == S_DIV) begin
            r_rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            r_quo <= {r_quo[DEN_W-2:0], ge};
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    // sequencer and motion state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pos    <= '0;
            r_target <= '0;
            r_free   <= 1'b0;
            r_run    <= 1'b0;
            r_dir    <= 1'b0;
            r_en_n   <= 1'b1;
            r_period <= '0;
            r_phase  <= '0;
            r_pulse  <= '0;
            r_step   <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (s_accept) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state <= S_EMIT;
                    case (r_req)
                        REQ_TICK: begin
                            r_step   <= n_step;
                            r_pulse  <= n_pulse;
                            r_phase  <= n_phase;
                            r_pos    <= n_pos;
                            r_dir    <= n_dir;
                            r_run    <= n_run;
                            r_period <= n_period;
                            r_target <= n_target;
                        end
                        REQ_RUN_VEL: begin
                            if (r_vel == '0) begin
                                r_free   <= 1'b0;
                                r_run    <= 1'b0;
                                r_period <= '0;
                                r_phase  <= '0;
                                r_target <= r_pos;
                            end else begin
                                r_free   <= 1'b1;
                                r_dir    <= !r_vel[VEL_W-1];
                                r_target <= r_pos;
                                r_state  <= S_MUL;
                            end
                        end
                        REQ_MOVE_ABS, REQ_MOVE_REL: begin
                            r_free <= 1'b0;
                            if (move_t == r_pos || r_vel == '0) begin
                                r_run    <= 1'b0;
                                r_period <= '0;
                                r_phase  <= '0;
                                r_target <= r_pos;
                            end else begin
                                r_target <= move_t;
                                r_dir    <= ($signed(move_t) > $signed(r_pos));
                                r_state  <= S_MUL;
                            end
                        end
                        REQ_ENABLE: begin
                            r_en_n <= 1'b0;
                        end
                        REQ_DISABLE: begin
                            r_en_n   <= 1'b1;
                            r_free   <= 1'b0;
                            r_run    <= 1'b0;
                            r_period <= '0;
                            r_phase  <= '0;
                            r_target <= r_pos;
                        end
                        default: ;
                    endcase
                end
                S_MUL: begin
                    r_state <= S_DINIT;
                end
                S_DINIT: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_cnt == DIV_LAST) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    // zero denominator leaves the quotient huge, so it saturates
                    r_run <= 1'b1;
                    if (p_fin != r_period) begin
                        r_period <= p_fin;
                        r_phase  <= '0;
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // output register: holds a result until its transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == S_EMIT && out_free) begin
            r_ovalid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT && out_free) begin
            r_odata <= OUT_W'({r_period, r_run, r_pos, r_en_n, r_dir, r_step});
        end
    end

endmodule
